[rtl/ubx_frame_receive_parser_top_assert.svh]
// Assertion macros for the frame parser checker
`ifndef UBX_FRAME_RECEIVE_PARSER_TOP_ASSERT_SVH
`define UBX_FRAME_RECEIVE_PARSER_TOP_ASSERT_SVH

// Clocked assertion with explicit clock and reset
`define UBX_ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ubx frame parser assertion failed");

// Assertion on the local clk and rst
`define UBX_ASSERT(label, prop) \
  `UBX_ASSERT_CLK(label, clk, rst, prop)

`endif

[rtl/ubx_frp_pkg.sv]
// Package: constants, types and field tables of the UBX frame parser
package ubx_frp_pkg;

  localparam int PAYLOAD_BYTES = 512;
  localparam int SAT_SLOTS     = 32;
  localparam int STORE_AW      = $clog2(PAYLOAD_BYTES);
  localparam int FILL_W        = $clog2(PAYLOAD_BYTES + 1);
  localparam int SLOT_W        = (SAT_SLOTS > 1) ? $clog2(SAT_SLOTS) : 1;
  localparam int OFF_W         = 16;
  localparam int PVT_FIELDS    = 13;

  typedef logic [OFF_W-1:0]  off_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [3:0]        idx_t;

  localparam logic [7:0] SYNC1_BYTE = 8'hB5;
  localparam logic [7:0] SYNC2_BYTE = 8'h62;
  localparam logic [7:0] CLS_ACK    = 8'h05;
  localparam logic [7:0] ID_ACK     = 8'h01;
  localparam logic [7:0] ID_NAK     = 8'h00;
  localparam logic [7:0] CLS_NAV    = 8'h01;
  localparam logic [7:0] ID_PVT     = 8'h07;
  localparam logic [7:0] ID_SAT     = 8'h35;

  localparam off_t SAT_COUNT_OFF = off_t'(5);
  localparam off_t SAT_CNO_OFF   = off_t'(10);
  localparam off_t SAT_STRIDE    = off_t'(12);

  localparam logic [3:0] RC_ACCEPT = 4'd0;
  localparam logic [3:0] RC_SAT    = 4'd14;

  typedef enum logic [3:0] {
    ST_SYNC1, ST_SYNC2, ST_CLASS, ST_ID, ST_LENLO, ST_LENHI, ST_BODY,
    ST_CKA, ST_CKB, ST_ACCEPT, ST_READ, ST_WAIT, ST_EMIT
  } ctl_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_START, OP_SYNC2, OP_CLASS, OP_ID, OP_LENLO, OP_LENHI,
    OP_BODY, OP_CHECK
  } byte_op_t;

  typedef enum logic [1:0] {EM_ACCEPT, EM_PVT, EM_SATCNT, EM_SAT} emit_sel_t;

  typedef enum logic [1:0] {FK_U32, FK_U8, FK_S32} field_kind_t;

  typedef struct packed {
    logic       in_ready;
    byte_op_t   op;
    logic       rd_en;
    off_t       rd_off;
    logic [1:0] rd_lane;
    logic       load_count;
    logic       emit;
    emit_sel_t  sel;
    logic [3:0] code;
    slot_t      slot;
    logic       sign_ext;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic in_fire;
    logic is_sync1;
    logic is_sync2;
    logic len_zero;
    logic body_done;
    logic cka_ok;
    logic ckb_ok;
    logic is_pvt;
    logic is_sat;
    logic out_free;
  } dp_status_t;

  function automatic logic [7:0] pvt_off(input idx_t idx);
    logic [7:0] off;
    case (idx)
      4'd0:    off = 8'd0;
      4'd1:    off = 8'd20;
      4'd2:    off = 8'd21;
      4'd3:    off = 8'd23;
      4'd4:    off = 8'd24;
      4'd5:    off = 8'd28;
      4'd6:    off = 8'd36;
      4'd7:    off = 8'd40;
      4'd8:    off = 8'd44;
      4'd9:    off = 8'd48;
      4'd10:   off = 8'd52;
      4'd11:   off = 8'd56;
      4'd12:   off = 8'd68;
      default: off = 8'd0;
    endcase
    return off;
  endfunction

  function automatic field_kind_t pvt_kind(input idx_t idx);
    field_kind_t k;
    case (idx)
      4'd1, 4'd2, 4'd3:                  k = FK_U8;
      4'd4, 4'd5, 4'd6, 4'd9, 4'd10, 4'd11: k = FK_S32;
      default:                           k = FK_U32;
    endcase
    return k;
  endfunction

endpackage

[rtl/ubx_frp_byte_if.sv]
// Interface: received byte channel
interface ubx_frp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/ubx_frp_result_if.sv]
// Interface: decoded result channel
interface ubx_frp_result_if;
  logic               valid;
  logic               ready;
  logic [3:0]         result_code;
  logic [4:0]         sat_index;
  logic signed [32:0] field_value;
  logic [31:0]        ack_total;
  logic [31:0]        nak_total;
  logic [31:0]        frames_started;
  logic [31:0]        frames_accepted;
  logic               last;

  modport source (output valid, output result_code, output sat_index, output field_value,
                  output ack_total, output nak_total, output frames_started,
                  output frames_accepted, output last, input ready);
  modport sink   (input valid, input result_code, input sat_index, input field_value,
                  input ack_total, input nak_total, input frames_started,
                  input frames_accepted, input last, output ready);
endinterface

[rtl/ubx_frp_ctrl.sv]
// Controller: frame phase tracking and result emission sequencing
module ubx_frp_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  ubx_frp_pkg::dp_status_t sts,
  output ubx_frp_pkg::dp_cmd_t    cmd
);

  ubx_frp_pkg::ctl_state_t state, state_next;
  ubx_frp_pkg::emit_sel_t  mode, mode_next;
  ubx_frp_pkg::idx_t       idx, idx_next;
  ubx_frp_pkg::slot_t      slot, slot_next;
  logic [1:0]              lane, lane_next;

  ubx_frp_pkg::field_kind_t kind;
  logic [1:0]               last_lane;
  ubx_frp_pkg::off_t        base_off;
  logic                     is_final;

  always_comb begin
    kind      = ubx_frp_pkg::pvt_kind(idx);
    last_lane = (mode == ubx_frp_pkg::EM_PVT && kind != ubx_frp_pkg::FK_U8) ? 2'd3 : 2'd0;
    case (mode)
      ubx_frp_pkg::EM_PVT:    base_off = ubx_frp_pkg::off_t'(ubx_frp_pkg::pvt_off(idx));
      ubx_frp_pkg::EM_SATCNT: base_off = ubx_frp_pkg::SAT_COUNT_OFF;
      ubx_frp_pkg::EM_SAT:    base_off = ubx_frp_pkg::off_t'(slot) * ubx_frp_pkg::SAT_STRIDE
                                         + ubx_frp_pkg::SAT_CNO_OFF;
      default:                base_off = '0;
    endcase
    if (mode == ubx_frp_pkg::EM_PVT) begin
      is_final = (idx == ubx_frp_pkg::idx_t'(ubx_frp_pkg::PVT_FIELDS - 1));
    end else begin
      is_final = (slot == ubx_frp_pkg::slot_t'(ubx_frp_pkg::SAT_SLOTS - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ubx_frp_pkg::ST_SYNC1;
      mode  <= ubx_frp_pkg::EM_ACCEPT;
      idx   <= '0;
      slot  <= '0;
      lane  <= '0;
    end else begin
      state <= state_next;
      mode  <= mode_next;
      idx   <= idx_next;
      slot  <= slot_next;
      lane  <= lane_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    mode_next  = mode;
    idx_next   = idx;
    slot_next  = slot;
    lane_next  = lane;
    case (state)
      ubx_frp_pkg::ST_SYNC1: begin
        if (sts.in_fire && sts.is_sync1) state_next = ubx_frp_pkg::ST_SYNC2;
      end
      ubx_frp_pkg::ST_SYNC2: begin
        if (sts.in_fire) begin
          state_next = sts.is_sync2 ? ubx_frp_pkg::ST_CLASS : ubx_frp_pkg::ST_SYNC1;
        end
      end
      ubx_frp_pkg::ST_CLASS: begin
        if (sts.in_fire) state_next = ubx_frp_pkg::ST_ID;
      end
      ubx_frp_pkg::ST_ID: begin
        if (sts.in_fire) state_next = ubx_frp_pkg::ST_LENLO;
      end
      ubx_frp_pkg::ST_LENLO: begin
        if (sts.in_fire) state_next = ubx_frp_pkg::ST_LENHI;
      end
      ubx_frp_pkg::ST_LENHI: begin
        if (sts.in_fire) begin
          state_next = sts.len_zero ? ubx_frp_pkg::ST_CKA : ubx_frp_pkg::ST_BODY;
        end
      end
      ubx_frp_pkg::ST_BODY: begin
        if (sts.in_fire && sts.body_done) state_next = ubx_frp_pkg::ST_CKA;
      end
      ubx_frp_pkg::ST_CKA: begin
        if (sts.in_fire) begin
          state_next = sts.cka_ok ? ubx_frp_pkg::ST_CKB : ubx_frp_pkg::ST_SYNC1;
        end
      end
      ubx_frp_pkg::ST_CKB: begin
        if (sts.in_fire) begin
          state_next = sts.ckb_ok ? ubx_frp_pkg::ST_ACCEPT : ubx_frp_pkg::ST_SYNC1;
        end
      end
      ubx_frp_pkg::ST_ACCEPT: begin
        if (sts.out_free) begin
          lane_next = '0;
          idx_next  = '0;
          if (sts.is_pvt) begin
            mode_next  = ubx_frp_pkg::EM_PVT;
            state_next = ubx_frp_pkg::ST_READ;
          end else if (sts.is_sat) begin
            mode_next  = ubx_frp_pkg::EM_SATCNT;
            state_next = ubx_frp_pkg::ST_READ;
          end else begin
            state_next = ubx_frp_pkg::ST_SYNC1;
          end
        end
      end
      ubx_frp_pkg::ST_READ: begin
        if (lane == last_lane) begin
          state_next = ubx_frp_pkg::ST_WAIT;
        end else begin
          lane_next = lane + 2'd1;
        end
      end
      ubx_frp_pkg::ST_WAIT: begin
        if (mode == ubx_frp_pkg::EM_SATCNT) begin
          mode_next  = ubx_frp_pkg::EM_SAT;
          slot_next  = '0;
          lane_next  = '0;
          state_next = ubx_frp_pkg::ST_READ;
        end else begin
          state_next = ubx_frp_pkg::ST_EMIT;
        end
      end
      ubx_frp_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          if (is_final) begin
            state_next = ubx_frp_pkg::ST_SYNC1;
          end else begin
            if (mode == ubx_frp_pkg::EM_PVT) begin
              idx_next = idx + 4'd1;
            end else begin
              slot_next = slot + 1'b1;
            end
            lane_next  = '0;
            state_next = ubx_frp_pkg::ST_READ;
          end
        end
      end
      default: state_next = ubx_frp_pkg::ST_SYNC1;
    endcase
  end

  // Outputs
  always_comb begin
    cmd            = '0;
    cmd.in_ready   = state inside {ubx_frp_pkg::ST_SYNC1, ubx_frp_pkg::ST_SYNC2,
                                   ubx_frp_pkg::ST_CLASS, ubx_frp_pkg::ST_ID,
                                   ubx_frp_pkg::ST_LENLO, ubx_frp_pkg::ST_LENHI,
                                   ubx_frp_pkg::ST_BODY, ubx_frp_pkg::ST_CKA,
                                   ubx_frp_pkg::ST_CKB};
    cmd.op         = ubx_frp_pkg::OP_NONE;
    cmd.rd_en      = (state == ubx_frp_pkg::ST_READ);
    cmd.rd_off     = base_off + ubx_frp_pkg::off_t'(lane);
    cmd.rd_lane    = lane;
    cmd.load_count = (state == ubx_frp_pkg::ST_WAIT) && (mode == ubx_frp_pkg::EM_SATCNT);
    cmd.sel        = mode;
    cmd.sign_ext   = (kind == ubx_frp_pkg::FK_S32);
    case (state)
      ubx_frp_pkg::ST_SYNC1:  cmd.op = ubx_frp_pkg::OP_START;
      ubx_frp_pkg::ST_SYNC2:  cmd.op = ubx_frp_pkg::OP_SYNC2;
      ubx_frp_pkg::ST_CLASS:  cmd.op = ubx_frp_pkg::OP_CLASS;
      ubx_frp_pkg::ST_ID:     cmd.op = ubx_frp_pkg::OP_ID;
      ubx_frp_pkg::ST_LENLO:  cmd.op = ubx_frp_pkg::OP_LENLO;
      ubx_frp_pkg::ST_LENHI:  cmd.op = ubx_frp_pkg::OP_LENHI;
      ubx_frp_pkg::ST_BODY:   cmd.op = ubx_frp_pkg::OP_BODY;
      ubx_frp_pkg::ST_CKB:    cmd.op = ubx_frp_pkg::OP_CHECK;
      ubx_frp_pkg::ST_ACCEPT: begin
        cmd.emit = sts.out_free;
        cmd.sel  = ubx_frp_pkg::EM_ACCEPT;
        cmd.code = ubx_frp_pkg::RC_ACCEPT;
        cmd.last = !(sts.is_pvt || sts.is_sat);
      end
      ubx_frp_pkg::ST_EMIT: begin
        cmd.emit = sts.out_free;
        cmd.last = is_final;
        if (mode == ubx_frp_pkg::EM_PVT) begin
          cmd.code = idx + 4'd1;
        end else begin
          cmd.code = ubx_frp_pkg::RC_SAT;
          cmd.slot = slot;
        end
      end
      default: cmd.op = ubx_frp_pkg::OP_NONE;
    endcase
  end

endmodule

[rtl/ubx_frp_datapath.sv]
// Datapath: checksum, frame header, payload memory, counters and result register
module ubx_frp_datapath (
  input  logic                    clk,
  input  logic                    rst,
  ubx_frp_byte_if.sink            rx,
  ubx_frp_result_if.source        res,
  input  ubx_frp_pkg::dp_cmd_t    cmd,
  output ubx_frp_pkg::dp_status_t sts
);

  logic [7:0]  sum_a, sum_b, frame_class, frame_id;
  logic [15:0] payload_length, payload_count;
  logic [ubx_frp_pkg::FILL_W-1:0] fill;
  logic [31:0] ack_cnt, nak_cnt, start_cnt, ok_cnt;

  logic [7:0] store [ubx_frp_pkg::PAYLOAD_BYTES];
  logic [7:0] mem_q;
  logic       rd_hit, rd_pend;
  logic [1:0] rd_lane_q;
  logic [31:0] asm_word;
  logic [7:0]  sat_count;

  logic        fire;
  logic [7:0]  b, sum_a_new, sum_b_new, rd_byte;
  logic [15:0] len_full, count_inc;
  logic        in_store;
  logic signed [32:0] value;

  assign rx.ready  = cmd.in_ready;
  assign fire      = rx.valid && cmd.in_ready;
  assign b         = rx.rx_byte;
  assign sum_a_new = sum_a + b;
  assign sum_b_new = sum_b + sum_a_new;
  assign len_full  = {b, payload_length[7:0]};
  assign count_inc = payload_count + 16'd1;
  assign in_store  = 32'(payload_count) < ubx_frp_pkg::PAYLOAD_BYTES;
  assign rd_byte   = rd_hit ? mem_q : 8'd0;

  always_comb begin
    sts.in_fire   = fire;
    sts.is_sync1  = (b == ubx_frp_pkg::SYNC1_BYTE);
    sts.is_sync2  = (b == ubx_frp_pkg::SYNC2_BYTE);
    sts.len_zero  = (len_full == 16'd0);
    sts.body_done = (count_inc >= payload_length);
    sts.cka_ok    = (sum_a == b);
    sts.ckb_ok    = (sum_b == b);
    sts.is_pvt    = (frame_class == ubx_frp_pkg::CLS_NAV) && (frame_id == ubx_frp_pkg::ID_PVT);
    sts.is_sat    = (frame_class == ubx_frp_pkg::CLS_NAV) && (frame_id == ubx_frp_pkg::ID_SAT);
    sts.out_free  = !res.valid || res.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_a          <= '0;
      sum_b          <= '0;
      frame_class    <= '0;
      frame_id       <= '0;
      payload_length <= '0;
      payload_count  <= '0;
      fill           <= '0;
      ack_cnt        <= '0;
      nak_cnt        <= '0;
      start_cnt      <= '0;
      ok_cnt         <= '0;
    end else if (fire) begin
      case (cmd.op)
        ubx_frp_pkg::OP_START: begin
          if (sts.is_sync1) start_cnt <= start_cnt + 32'd1;
        end
        ubx_frp_pkg::OP_SYNC2: begin
          if (sts.is_sync2) begin
            sum_a <= '0;
            sum_b <= '0;
          end
        end
        ubx_frp_pkg::OP_CLASS: begin
          frame_class <= b;
          sum_a       <= sum_a_new;
          sum_b       <= sum_b_new;
        end
        ubx_frp_pkg::OP_ID: begin
          frame_id <= b;
          sum_a    <= sum_a_new;
          sum_b    <= sum_b_new;
        end
        ubx_frp_pkg::OP_LENLO: begin
          payload_length <= {8'd0, b};
          sum_a          <= sum_a_new;
          sum_b          <= sum_b_new;
        end
        ubx_frp_pkg::OP_LENHI: begin
          payload_length <= len_full;
          payload_count  <= '0;
          sum_a          <= sum_a_new;
          sum_b          <= sum_b_new;
        end
        ubx_frp_pkg::OP_BODY: begin
          payload_count <= count_inc;
          sum_a         <= sum_a_new;
          sum_b         <= sum_b_new;
          if (in_store && (32'(count_inc) > 32'(fill))) begin
            fill <= ubx_frp_pkg::FILL_W'(count_inc);
          end
        end
        ubx_frp_pkg::OP_CHECK: begin
          if (sts.ckb_ok) begin
            ok_cnt <= ok_cnt + 32'd1;
            if (frame_class == ubx_frp_pkg::CLS_ACK && frame_id == ubx_frp_pkg::ID_ACK) begin
              ack_cnt <= ack_cnt + 32'd1;
            end
            if (frame_class == ubx_frp_pkg::CLS_ACK && frame_id == ubx_frp_pkg::ID_NAK) begin
              nak_cnt <= nak_cnt + 32'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fire && cmd.op == ubx_frp_pkg::OP_BODY && in_store) begin
      store[payload_count[ubx_frp_pkg::STORE_AW-1:0]] <= b;
    end
    if (cmd.rd_en) begin
      mem_q  <= store[cmd.rd_off[ubx_frp_pkg::STORE_AW-1:0]];
      rd_hit <= 32'(cmd.rd_off) < 32'(fill);
    end
    rd_lane_q <= cmd.rd_lane;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      if (rd_lane_q == 2'd0) begin
        asm_word <= {24'd0, rd_byte};
      end else begin
        asm_word[rd_lane_q*8 +: 8] <= rd_byte;
      end
    end
    if (cmd.load_count) begin
      sat_count <= rd_byte;
    end
  end

  always_comb begin
    case (cmd.sel)
      ubx_frp_pkg::EM_ACCEPT: value = {17'd0, frame_class, frame_id};
      ubx_frp_pkg::EM_PVT:    value = cmd.sign_ext ? {asm_word[31], asm_word}
                                                   : {1'b0, asm_word};
      ubx_frp_pkg::EM_SAT:    value = (8'(cmd.slot) < sat_count) ? {25'd0, asm_word[7:0]}
                                                                 : 33'sd0;
      default:                value = 33'sd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (cmd.emit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res.result_code     <= cmd.code;
      res.sat_index       <= 5'(cmd.slot);
      res.field_value     <= value;
      res.ack_total       <= ack_cnt;
      res.nak_total       <= nak_cnt;
      res.frames_started  <= start_cnt;
      res.frames_accepted <= ok_cnt;
      res.last            <= cmd.last;
    end
  end

endmodule

[rtl/ubx_frame_receive_parser_top.sv]
// Top level: UBX binary frame receive parser with Fletcher-8 check
// Takes one received byte per item on rx and, for every frame whose two
// checksum bytes match, sends results on res: first a frame-accepted item
// (class*256+id), then the 13 NAV-PVT fields or the 32 NAV-SAT CNO slots.
// While a frame is being received a byte is taken in every cycle that rx
// offers one. After the second checksum byte of a good frame, rx is held
// off while the results go out: the accept item first, then, for NAV-PVT,
// each field read byte by byte (one byte or four) through the single read
// port of the payload memory, or, for NAV-SAT, the satellite count byte and
// then each slot's CNO byte through that port; any stall on res holds rx
// off longer. The last result of a frame can wait in the output register
// while the next frame's bytes are taken. Payload bytes past the 512-byte
// store are checksummed and dropped; unwritten store entries read as zero
// through a fill count, so no clearing pass follows reset. Counters wrap at
// 32 bits.
module ubx_frame_receive_parser_top (
  input  logic             clk,
  input  logic             rst,
  ubx_frp_byte_if.sink     rx,
  ubx_frp_result_if.source res
);

  ubx_frp_pkg::dp_cmd_t    cmd;
  ubx_frp_pkg::dp_status_t sts;

  ubx_frp_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  ubx_frp_datapath u_dp (
    .clk (clk),
    .rst (rst),
    .rx  (rx),
    .res (res),
    .cmd (cmd),
    .sts (sts)
  );

endmodule

[rtl/ubx_frp_checker.sv]
// Checker: port-level assertions for the frame parser, bound to the top level
`include "ubx_frame_receive_parser_top_assert.svh"

module ubx_frp_checker (
  input logic               clk,
  input logic               rst,
  input logic               rx_ready,
  input logic               res_valid,
  input logic               res_ready,
  input logic               res_last,
  input logic [3:0]         res_code,
  input logic [4:0]         res_sat_index,
  input logic signed [32:0] res_value
);

  `UBX_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(res_value))
  `UBX_ASSERT(a_burst_blocks_rx, res_valid && !res_last |-> !rx_ready)
  `UBX_ASSERT(a_slot_zero, res_valid && res_code != ubx_frp_pkg::RC_SAT |-> res_sat_index == 5'd0)
  `UBX_ASSERT(a_cno_byte, res_valid && res_code == ubx_frp_pkg::RC_SAT |-> res_value[32:8] == 25'd0)

endmodule

bind ubx_frame_receive_parser_top ubx_frp_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .rx_ready      (rx.ready),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_last      (res.last),
  .res_code      (res.result_code),
  .res_sat_index (res.sat_index),
  .res_value     (res.field_value)
);

[test/testbench.sv]
`timescale 1ns / 1ps
// Testbench of the UBX frame parser: byte stream in, decoded results checked against a predictor
module testbench;

  typedef struct packed {
    logic [3:0]  code;
    logic [4:0]  slot;
    logic [32:0] value;
    logic [31:0] acks;
    logic [31:0] naks;
    logic [31:0] starts;
    logic [31:0] accepts;
    logic        last;
  } parse_result_t;

  typedef struct packed {
    logic [7:0]    data;
    logic          fixed;
    parse_result_t want;
  } stim_row_t;

  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 300;
  localparam int PHASE_BYTES  = 80;
  localparam int PVT_LEN      = 92;
  localparam int NO_COUNT     = -1;
  localparam int FRAME_GOOD   = 0;
  localparam int FAULT_CKA    = 1;
  localparam int FAULT_CKB    = 2;

  localparam parse_result_t NO_RESULT = '0;

  localparam stim_row_t DIRECTED [28] = '{
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'hB5, 1'b0, NO_RESULT},
    '{8'hB5, 1'b0, NO_RESULT},
    '{8'h62, 1'b0, NO_RESULT},
    '{8'hB5, 1'b0, NO_RESULT},
    '{8'h62, 1'b0, NO_RESULT},
    '{8'h05, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h06, 1'b0, NO_RESULT},
    '{8'h17, 1'b1, '{ubx_frp_pkg::RC_ACCEPT, 5'd0, 33'h00501,
                     32'd1, 32'd0, 32'd2, 32'd1, 1'b1}},
    '{8'hB5, 1'b0, NO_RESULT},
    '{8'h62, 1'b0, NO_RESULT},
    '{8'h05, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h05, 1'b0, NO_RESULT},
    '{8'h14, 1'b1, '{ubx_frp_pkg::RC_ACCEPT, 5'd0, 33'h00500,
                     32'd1, 32'd1, 32'd3, 32'd2, 1'b1}},
    '{8'hB5, 1'b0, NO_RESULT},
    '{8'h62, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, NO_RESULT},
    '{8'h07, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h08, 1'b0, NO_RESULT},
    '{8'h19, 1'b0, NO_RESULT}
  };

  localparam logic [7:0] PVT_OFFSET [ubx_frp_pkg::PVT_FIELDS] = '{
    8'd0, 8'd20, 8'd21, 8'd23, 8'd24, 8'd28, 8'd36, 8'd40, 8'd44, 8'd48, 8'd52, 8'd56, 8'd68
  };
  localparam ubx_frp_pkg::field_kind_t PVT_FORM [ubx_frp_pkg::PVT_FIELDS] = '{
    ubx_frp_pkg::FK_U32, ubx_frp_pkg::FK_U8, ubx_frp_pkg::FK_U8, ubx_frp_pkg::FK_U8,
    ubx_frp_pkg::FK_S32, ubx_frp_pkg::FK_S32, ubx_frp_pkg::FK_S32, ubx_frp_pkg::FK_U32,
    ubx_frp_pkg::FK_U32, ubx_frp_pkg::FK_S32, ubx_frp_pkg::FK_S32, ubx_frp_pkg::FK_S32,
    ubx_frp_pkg::FK_U32
  };

  logic clk;
  logic rst;

  ubx_frp_byte_if   rx ();
  ubx_frp_result_if res ();

  ubx_frame_receive_parser_top u_top (
    .clk (clk),
    .rst (rst),
    .rx  (rx),
    .res (res)
  );

  ubx_frp_pkg::ctl_state_t parse_phase;
  logic [7:0]  ck_a;
  logic [7:0]  ck_b;
  logic [7:0]  cur_class;
  logic [7:0]  cur_id;
  logic [15:0] cur_len;
  logic [15:0] cur_count;
  logic [7:0]  payload_copy [ubx_frp_pkg::PAYLOAD_BYTES];
  logic [31:0] acks;
  logic [31:0] naks;
  logic [31:0] starts;
  logic [31:0] accepts;

  parse_result_t new_results[$];
  parse_result_t expected_results[$];
  stim_row_t     offered_bytes[$];

  int errors = 0;
  int bytes_in = 0;
  int results_seen = 0;
  int pvt_frames = 0;
  int sat_frames = 0;
  int source_idle_pct = 0;
  int sink_idle_pct = 0;
  bit hold_request = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] stored(input int off);
    return (off < ubx_frp_pkg::PAYLOAD_BYTES) ?
           payload_copy[off[ubx_frp_pkg::STORE_AW-1:0]] : 8'h00;
  endfunction

  task automatic sum_in(input logic [7:0] b);
    ck_a = ck_a + b;
    ck_b = ck_b + ck_a;
  endtask

  task automatic add_result(input logic [3:0] code, input logic [4:0] slot,
                            input logic [32:0] value);
    new_results.push_back(parse_result_t'{code, slot, value, acks, naks, starts, accepts, 1'b0});
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic [31:0]   word;
    logic [7:0]    sv_count;
    parse_result_t tail;
    new_results.delete();
    case (parse_phase)
      ubx_frp_pkg::ST_SYNC1: begin
        if (b == ubx_frp_pkg::SYNC1_BYTE) begin
          starts++;
          parse_phase = ubx_frp_pkg::ST_SYNC2;
        end
      end
      ubx_frp_pkg::ST_SYNC2: begin
        if (b == ubx_frp_pkg::SYNC2_BYTE) begin
          ck_a = '0;
          ck_b = '0;
          parse_phase = ubx_frp_pkg::ST_CLASS;
        end else begin
          parse_phase = ubx_frp_pkg::ST_SYNC1;
        end
      end
      ubx_frp_pkg::ST_CLASS: begin
        cur_class = b;
        sum_in(b);
        parse_phase = ubx_frp_pkg::ST_ID;
      end
      ubx_frp_pkg::ST_ID: begin
        cur_id = b;
        sum_in(b);
        parse_phase = ubx_frp_pkg::ST_LENLO;
      end
      ubx_frp_pkg::ST_LENLO: begin
        cur_len = {8'h00, b};
        sum_in(b);
        parse_phase = ubx_frp_pkg::ST_LENHI;
      end
      ubx_frp_pkg::ST_LENHI: begin
        cur_len = {b, cur_len[7:0]};
        cur_count = '0;
        sum_in(b);
        parse_phase = (cur_len == 16'd0) ? ubx_frp_pkg::ST_CKA : ubx_frp_pkg::ST_BODY;
      end
      ubx_frp_pkg::ST_BODY: begin
        if (cur_count < ubx_frp_pkg::PAYLOAD_BYTES) begin
          payload_copy[cur_count[ubx_frp_pkg::STORE_AW-1:0]] = b;
        end
        cur_count = cur_count + 16'd1;
        sum_in(b);
        if (cur_count >= cur_len) parse_phase = ubx_frp_pkg::ST_CKA;
      end
      ubx_frp_pkg::ST_CKA: begin
        parse_phase = (ck_a == b) ? ubx_frp_pkg::ST_CKB : ubx_frp_pkg::ST_SYNC1;
      end
      ubx_frp_pkg::ST_CKB: begin
        parse_phase = ubx_frp_pkg::ST_SYNC1;
        if (ck_b == b) begin
          if (cur_class == ubx_frp_pkg::CLS_ACK && cur_id == ubx_frp_pkg::ID_ACK) acks++;
          if (cur_class == ubx_frp_pkg::CLS_ACK && cur_id == ubx_frp_pkg::ID_NAK) naks++;
          accepts++;
          add_result(ubx_frp_pkg::RC_ACCEPT, 5'd0, {17'b0, cur_class, cur_id});
          if (cur_class == ubx_frp_pkg::CLS_NAV && cur_id == ubx_frp_pkg::ID_PVT) begin
            pvt_frames++;
            for (int i = 0; i < ubx_frp_pkg::PVT_FIELDS; i++) begin
              word = {stored(int'(PVT_OFFSET[i]) + 3), stored(int'(PVT_OFFSET[i]) + 2),
                      stored(int'(PVT_OFFSET[i]) + 1), stored(int'(PVT_OFFSET[i]))};
              case (PVT_FORM[i])
                ubx_frp_pkg::FK_U8:
                  add_result(4'(i + 1), 5'd0, {25'b0, stored(int'(PVT_OFFSET[i]))});
                ubx_frp_pkg::FK_S32: add_result(4'(i + 1), 5'd0, {word[31], word});
                default:             add_result(4'(i + 1), 5'd0, {1'b0, word});
              endcase
            end
          end else if (cur_class == ubx_frp_pkg::CLS_NAV && cur_id == ubx_frp_pkg::ID_SAT) begin
            sat_frames++;
            sv_count = stored(int'(ubx_frp_pkg::SAT_COUNT_OFF));
            for (int s = 0; s < ubx_frp_pkg::SAT_SLOTS; s++) begin
              add_result(ubx_frp_pkg::RC_SAT, 5'(s), (s < sv_count) ?
                         {25'b0, stored(int'(ubx_frp_pkg::SAT_STRIDE) * s +
                                        int'(ubx_frp_pkg::SAT_CNO_OFF))} : 33'd0);
            end
          end
        end
      end
      default: parse_phase = ubx_frp_pkg::ST_SYNC1;
    endcase
    if (new_results.size() > 0) begin
      tail = new_results.pop_back();
      tail.last = 1'b1;
      new_results.push_back(tail);
    end
  endtask

  task automatic compare_field(input string name, input logic [32:0] want, input logic [32:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_result(input parse_result_t got);
    parse_result_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result: code %0d slot %0d value %0h", $time,
               got.code, got.slot, got.value);
    end else begin
      want = expected_results.pop_front();
      compare_field("result_code", 33'(want.code), 33'(got.code));
      compare_field("sat_index", 33'(want.slot), 33'(got.slot));
      compare_field("field_value", want.value, got.value);
      compare_field("ack_total", 33'(want.acks), 33'(got.acks));
      compare_field("nak_total", 33'(want.naks), 33'(got.naks));
      compare_field("frames_started", 33'(want.starts), 33'(got.starts));
      compare_field("frames_accepted", 33'(want.accepts), 33'(got.accepts));
      compare_field("last", 33'(want.last), 33'(got.last));
    end
  endtask

  always @(posedge clk) begin : monitor
    stim_row_t row;
    if (!rst) begin
      if (res.valid && res.ready) begin
        check_result(parse_result_t'{res.result_code, res.sat_index, res.field_value,
                                     res.ack_total, res.nak_total, res.frames_started,
                                     res.frames_accepted, res.last});
      end
      if (rx.valid && rx.ready) begin
        row = offered_bytes.pop_front();
        bytes_in++;
        decode_byte(row.data);
        if (row.fixed) begin
          expected_results.push_back(row.want);
        end else begin
          foreach (new_results[i]) expected_results.push_back(new_results[i]);
        end
      end
    end
  end

  initial begin : sink_driver
    int hold_left;
    hold_left = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (rx.valid && rx.ready) || (res.valid && res.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: timeout, no item moved for %0d cycles", $time, STALL_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_byte(input logic [7:0] data, input logic fixed, input parse_result_t want);
    while ($urandom_range(99) < source_idle_pct) begin
      rx.valid <= 1'b0;
      @(posedge clk);
    end
    offered_bytes.push_back(stim_row_t'{data, fixed, want});
    rx.valid   <= 1'b1;
    rx.rx_byte <= data;
    @(posedge clk);
    while (!rx.ready) @(posedge clk);
  endtask

  task automatic send_raw(input logic [7:0] data);
    send_byte(data, 1'b0, NO_RESULT);
  endtask

  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id, input int len,
                            input int sv_count, input int fault);
    logic [7:0]  sa;
    logic [7:0]  sb;
    logic [7:0]  b;
    logic [15:0] len16;
    len16 = 16'(len);
    sa = '0;
    sb = '0;
    send_raw(ubx_frp_pkg::SYNC1_BYTE);
    send_raw(ubx_frp_pkg::SYNC2_BYTE);
    for (int i = 0; i < len + 4; i++) begin
      if (i == 0) b = cls;
      else if (i == 1) b = id;
      else if (i == 2) b = len16[7:0];
      else if (i == 3) b = len16[15:8];
      else if (i == 4 + int'(ubx_frp_pkg::SAT_COUNT_OFF) && sv_count != NO_COUNT) b = 8'(sv_count);
      else if ($urandom_range(9) == 0) begin
        b = $urandom_range(1) ? ubx_frp_pkg::SYNC1_BYTE : ubx_frp_pkg::SYNC2_BYTE;
      end
      else b = 8'($urandom);
      sa = sa + b;
      sb = sb + sa;
      send_raw(b);
    end
    case (fault)
      FAULT_CKA: begin
        send_raw(sa ^ 8'($urandom_range(1, 255)));
        // keep the stray check byte from opening a frame
        send_raw((sb == ubx_frp_pkg::SYNC1_BYTE) ? 8'h00 : sb);
      end
      FAULT_CKB: begin
        send_raw(sa);
        send_raw(sb ^ 8'($urandom_range(1, 255)));
      end
      default: begin
        send_raw(sa);
        send_raw(sb);
      end
    endcase
  endtask

  task automatic send_random_frame();
    int pick;
    int roll;
    int fault;
    int n;
    pick = $urandom_range(99);
    roll = $urandom_range(99);
    fault = (roll < 10) ? FAULT_CKA : (roll < 20) ? FAULT_CKB : FRAME_GOOD;
    if ($urandom_range(9) < 3) repeat ($urandom_range(1, 3)) send_raw(8'($urandom_range(0, 180)));
    if ($urandom_range(9) == 0) begin
      send_raw(ubx_frp_pkg::SYNC1_BYTE);
      send_raw(8'($urandom_range(0, 97)));
    end
    if (pick < 25) begin
      n = ($urandom_range(2) == 0) ? $urandom_range(0, PVT_LEN - 1) : PVT_LEN;
      send_frame(ubx_frp_pkg::CLS_NAV, ubx_frp_pkg::ID_PVT, n, NO_COUNT, fault);
    end else if (pick < 45) begin
      n = ($urandom_range(7) == 0) ? ubx_frp_pkg::SAT_SLOTS : $urandom_range(0, 6);
      send_frame(ubx_frp_pkg::CLS_NAV, ubx_frp_pkg::ID_SAT, 8 + 12 * n,
                 ($urandom_range(3) == 0) ? $urandom_range(0, 255) : n, fault);
    end else if (pick < 55) begin
      send_frame(ubx_frp_pkg::CLS_ACK, ubx_frp_pkg::ID_ACK, $urandom_range(0, 4), NO_COUNT, fault);
    end else if (pick < 65) begin
      send_frame(ubx_frp_pkg::CLS_ACK, ubx_frp_pkg::ID_NAK, $urandom_range(0, 4), NO_COUNT, fault);
    end else if (pick < 72) begin
      send_frame(ubx_frp_pkg::CLS_ACK, 8'($urandom_range(2, 255)), $urandom_range(0, 8),
                 NO_COUNT, fault);
    end else if (pick < 80) begin
      send_frame(ubx_frp_pkg::CLS_NAV, 8'($urandom), $urandom_range(0, 16), NO_COUNT, fault);
    end else begin
      send_frame(8'($urandom), 8'($urandom), $urandom_range(0, 16), NO_COUNT, fault);
    end
  endtask

  task automatic run_phase(input int src_pct, input int snk_pct, input int nbytes);
    int stop_at;
    source_idle_pct = src_pct;
    sink_idle_pct = snk_pct;
    stop_at = bytes_in + nbytes;
    while (bytes_in < stop_at) send_random_frame();
  endtask

  initial begin
    parse_phase = ubx_frp_pkg::ST_SYNC1;
    ck_a = '0;
    ck_b = '0;
    cur_class = '0;
    cur_id = '0;
    cur_len = '0;
    cur_count = '0;
    foreach (payload_copy[i]) payload_copy[i] = '0;
    acks = '0;
    naks = '0;
    starts = '0;
    accepts = '0;

    rst        <= 1'b1;
    rx.valid   <= 1'b0;
    rx.rx_byte <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    source_idle_pct = 13;
    sink_idle_pct = 58;
    foreach (DIRECTED[i]) send_byte(DIRECTED[i].data, DIRECTED[i].fixed, DIRECTED[i].want);
    run_phase(13, 58, PHASE_BYTES);
    run_phase(58, 13, PHASE_BYTES);

    // hold the result side while full frames keep arriving
    source_idle_pct = 0;
    sink_idle_pct = 0;
    hold_request = 1'b1;
    send_frame(ubx_frp_pkg::CLS_NAV, ubx_frp_pkg::ID_PVT, PVT_LEN, NO_COUNT, FRAME_GOOD);
    send_frame(ubx_frp_pkg::CLS_NAV, ubx_frp_pkg::ID_SAT, 8 + 12 * 4, 4, FRAME_GOOD);
    run_phase(0, 0, PHASE_BYTES);

    send_frame(ubx_frp_pkg::CLS_NAV, ubx_frp_pkg::ID_PVT, 24, NO_COUNT, FRAME_GOOD);
    rx.valid <= 1'b0;

    while (offered_bytes.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d bytes parsed, %0d results checked, %0d good frames of %0d started.",
             bytes_in, results_seen, accepts, starts);
    $display("Run: %0d NAV-PVT, %0d NAV-SAT, %0d ACK, %0d NAK, idle mixes and a held sink.",
             pvt_frames, sat_frames, acks, naks);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
